### src/lrn_pkg.sv
package lrn_pkg;

	localparam int MAX_WINDOW = 15;
	localparam int LINE_IW    = $clog2(MAX_WINDOW);
	localparam int SAMPLE_W   = 16;
	localparam int SQ_W       = 32;
	localparam int ACC_W      = 36;
	localparam int SCALE_W    = 32;
	localparam int SZ_W       = 4;
	localparam int ALPHA_W    = 24;
	localparam int BETA_W     = 16;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_IW    = $clog2(FIFO_DEPTH);
	localparam logic [SCALE_W-1:0] ONE_Q22 = 32'h0040_0000;

	localparam int PADDR_W = 4;

	typedef enum logic [1:0] {
		REG_WINDOW_SIZE = 2'd0,
		REG_ALPHA       = 2'd1,
		REG_BETA        = 2'd2,
		REG_NONE        = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic [SCALE_W-1:0]  scale;
		logic                last;
	} lrn_entry_t;

	// round(65536 * 2^(-2^-(k+1)))
	function automatic logic [15:0] exp_step(input logic [3:0] k);
		logic [15:0] c;
		unique case (k)
			4'd0:    c = 16'd46341;
			4'd1:    c = 16'd55109;
			4'd2:    c = 16'd60097;
			4'd3:    c = 16'd62757;
			4'd4:    c = 16'd64132;
			4'd5:    c = 16'd64830;
			4'd6:    c = 16'd65182;
			4'd7:    c = 16'd65359;
			4'd8:    c = 16'd65447;
			4'd9:    c = 16'd65492;
			4'd10:   c = 16'd65514;
			4'd11:   c = 16'd65525;
			default: c = 16'd0;
		endcase
		return c;
	endfunction

endpackage

### src/lrn_if.sv
interface lrn_in_if import lrn_pkg::*;;
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;
	logic                last_channel;
	modport source (output valid, output sample, output last_channel, input ready);
	modport sink (input valid, input sample, input last_channel, output ready);
endinterface

interface lrn_out_if import lrn_pkg::*;;
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] normalized;
	logic [SCALE_W-1:0]  scale_value;
	logic                last_out;
	modport source (output valid, output normalized, output scale_value, output last_out,
		input ready);
	modport sink (input valid, input normalized, input scale_value, input last_out,
		output ready);
endinterface

### src/lrn_fifo.sv
module lrn_fifo import lrn_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  lrn_entry_t push_data,
	output logic       full,
	input  logic       pop,
	output lrn_entry_t pop_data,
	output logic       empty
);
	lrn_entry_t           mem_q [FIFO_DEPTH];
	logic [FIFO_IW-1:0]   wr_q, rd_q;
	logic [FIFO_IW:0]     cnt_q;

	assign full     = (cnt_q == FIFO_IW'(0) + (FIFO_IW+1)'(FIFO_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wr_q <= wr_q + 1'b1;
			if (pop && !empty) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (FIFO_IW+1)'(push && !full) - (FIFO_IW+1)'(pop && !empty);
		end
	end
endmodule

### src/lrn_front.sv
module lrn_front import lrn_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	lrn_in_if.sink             in_ch,
	input  logic [SZ_W-1:0]    window_size,
	input  logic [ALPHA_W-1:0] alpha_over_size,
	output logic               push,
	output lrn_entry_t         push_data,
	input  logic               full
);
	typedef enum logic [4:0] {
		F_IDLE  = 5'b00001,
		F_MULQ  = 5'b00010,
		F_SHIFT = 5'b00100,
		F_SUM   = 5'b01000,
		F_PUSH  = 5'b10000
	} f_state_t;

	f_state_t            state_q;
	logic [SAMPLE_W-1:0] x_q;
	logic                last_q;
	logic [31:0]         asq_q;
	logic [SQ_W-1:0]     sqn_q;
	logic [SQ_W-1:0]     sq_line_q  [MAX_WINDOW];
	logic [SAMPLE_W-1:0] smp_line_q [MAX_WINDOW];
	logic [3:0]          pos_q;
	logic [2:0]          j_q;
	logic [3:0]          n_q;
	logic [LINE_IW-1:0]  i_q;
	logic [ACC_W-1:0]    acc_q;

	logic [SZ_W-1:0]     sz;
	logic [2:0]          pre, post;
	logic [15:0]         ax;
	logic [56:0]         qprod;
	logic [LINE_IW-1:0]  hi;
	logic                main_emit;
	logic [3:0]          pend;
	logic [ACC_W:0]      scale_wide;

	assign sz   = (window_size == '0) ? SZ_W'(1) : window_size;
	assign pre  = 3'((sz - 1'b1) >> 1);
	assign post = 3'(sz - 1'b1) - pre;
	assign ax   = in_ch.sample[15] ? (16'd0 - in_ch.sample) : in_ch.sample;
	assign qprod = 57'(asq_q) * 57'(alpha_over_size) + 57'(1) * 57'(33554432);
	assign hi   = LINE_IW'(j_q) + LINE_IW'(pre);

	// pending flush count after this channel: min(pos+1, post) on a last item
	assign main_emit = (pos_q >= 4'(post));
	always_comb begin
		if (!last_q) pend = '0;
		else if ((5'(pos_q) + 5'd1) < 5'(post)) pend = pos_q + 1'b1;
		else pend = 4'(post);
	end

	assign scale_wide = (ACC_W+1)'(acc_q) + (ACC_W+1)'(ONE_Q22);

	assign in_ch.ready      = (state_q == F_IDLE);
	assign push             = (state_q == F_PUSH) && !full;
	assign push_data.sample = smp_line_q[j_q];
	assign push_data.scale  = (scale_wide > (ACC_W+1)'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
		: scale_wide[SCALE_W-1:0];
	assign push_data.last   = last_q && (n_q == 4'd1);

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_ch.valid) begin
			x_q    <= in_ch.sample;
			last_q <= in_ch.last_channel;
			asq_q  <= 32'(ax) * 32'(ax);
		end
		if (state_q == F_MULQ) sqn_q <= SQ_W'(qprod >> 26);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			pos_q   <= '0;
			j_q     <= '0;
			n_q     <= '0;
			i_q     <= '0;
			acc_q   <= '0;
			for (int k = 0; k < MAX_WINDOW; k++) begin
				sq_line_q[k]  <= '0;
				smp_line_q[k] <= '0;
			end
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_ch.valid) state_q <= F_MULQ;
				end
				F_MULQ: begin
					state_q <= F_SHIFT;
				end
				F_SHIFT: begin
					// advance both lines, newest at index 0
					for (int k = MAX_WINDOW-1; k > 0; k--) begin
						sq_line_q[k]  <= sq_line_q[k-1];
						smp_line_q[k] <= smp_line_q[k-1];
					end
					sq_line_q[0]  <= sqn_q;
					smp_line_q[0] <= x_q;
					if (pos_q != 4'd15) pos_q <= pos_q + 1'b1;
					j_q   <= main_emit ? post : pos_q[2:0];
					n_q   <= 4'(main_emit) + pend;
					i_q   <= '0;
					acc_q <= '0;
					if (main_emit || pend != '0) state_q <= F_SUM;
					else state_q <= F_IDLE;
				end
				F_SUM: begin
					acc_q <= acc_q + ACC_W'(sq_line_q[i_q]);
					i_q   <= i_q + 1'b1;
					if (i_q == hi) state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!full) begin
						n_q   <= n_q - 1'b1;
						j_q   <= j_q - 1'b1;
						i_q   <= '0;
						acc_q <= '0;
						if (n_q == 4'd1) begin
							state_q <= F_IDLE;
							// drop the vector's history at its end
							if (last_q) begin
								pos_q <= '0;
								for (int k = 0; k < MAX_WINDOW; k++) begin
									sq_line_q[k]  <= '0;
									smp_line_q[k] <= '0;
								end
							end
						end else begin
							state_q <= F_SUM;
						end
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end
endmodule

### src/lrn_back.sv
module lrn_back import lrn_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [BETA_W-1:0] beta,
	input  logic              empty,
	input  lrn_entry_t        pop_data,
	output logic              pop,
	lrn_out_if.source         out_ch
);
	typedef enum logic [7:0] {
		B_IDLE = 8'b00000001,
		B_NORM = 8'b00000010,
		B_LOG  = 8'b00000100,
		B_Y    = 8'b00001000,
		B_EXP  = 8'b00010000,
		B_SHG  = 8'b00100000,
		B_MUL  = 8'b01000000,
		B_OUT  = 8'b10000000
	} b_state_t;

	b_state_t            state_q;
	lrn_entry_t          ent_q;
	logic [30:0]         m_q;
	logic [3:0]          ipl_q;
	logic [15:0]         frac_q;
	logic [3:0]          cnt_q;
	logic [18:0]         y_q;
	logic [16:0]         g_q;
	logic [15:0]         res_q;
	logic                ovalid_q;
	logic [SAMPLE_W-1:0] onorm_q;
	logic [SCALE_W-1:0]  oscale_q;
	logic                olast_q;

	logic [4:0]          e;
	logic [30:0]         m_norm;
	logic [61:0]         mm;
	logic [36:0]         yprod;
	logic [32:0]         gprod;
	logic [33:0]         p;
	logic [34:0]         pr;
	logic [18:0]         v;
	logic                load_out;

	// leading one of the scale, between bits 22 and 31
	always_comb begin
		e = 5'd22;
		for (int b = 22; b < 32; b++) begin
			if (ent_q.scale[b]) e = 5'(b);
		end
	end
	assign m_norm = (e >= 5'd30) ? 31'(ent_q.scale >> (e - 5'd30))
		: 31'(ent_q.scale << (5'd30 - e));

	assign mm    = 62'(m_q) * 62'(m_q);
	assign yprod = 37'(beta) * 37'({ipl_q, frac_q}) + 37'(131072);
	assign gprod = 33'(g_q) * 33'(exp_step(cnt_q)) + 33'(32768);
	assign p     = $signed(ent_q.sample) * $signed({1'b0, g_q});
	assign pr    = 35'($signed(p)) + 35'sd32768;
	assign v     = pr[34:16];

	assign pop      = (state_q == B_IDLE) && !empty;
	assign load_out = (state_q == B_OUT) && (!ovalid_q || out_ch.ready);

	assign out_ch.valid       = ovalid_q;
	assign out_ch.normalized  = onorm_q;
	assign out_ch.scale_value = oscale_q;
	assign out_ch.last_out    = olast_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: if (!empty) ent_q <= pop_data;
			B_NORM: begin
				m_q    <= m_norm;
				ipl_q  <= 4'(e - 5'd22);
				frac_q <= '0;
			end
			B_LOG: begin
				if (mm[61]) begin
					m_q    <= mm[61:31];
					frac_q <= {frac_q[14:0], 1'b1};
				end else begin
					m_q    <= mm[60:30];
					frac_q <= {frac_q[14:0], 1'b0};
				end
			end
			B_Y: begin
				y_q <= yprod[36:18];
				g_q <= 17'd65536;
			end
			B_EXP: begin
				if (y_q[4'd11 - cnt_q]) g_q <= gprod[32:16];
			end
			B_SHG: begin
				if (y_q[18:12] >= 7'd17) g_q <= '0;
				else g_q <= g_q >> y_q[16:12];
			end
			B_MUL: begin
				// saturate to signed 16
				if ($signed(v) > 19'sd32767) res_q <= 16'h7FFF;
				else if ($signed(v) < -19'sd32768) res_q <= 16'h8000;
				else res_q <= v[15:0];
			end
			B_OUT: ;
			default: ;
		endcase
		if (load_out) begin
			onorm_q  <= res_q;
			oscale_q <= ent_q.scale;
			olast_q  <= ent_q.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (load_out) ovalid_q <= 1'b1;
			else if (out_ch.ready) ovalid_q <= 1'b0;
			unique case (state_q)
				B_IDLE: if (!empty) state_q <= B_NORM;
				B_NORM: begin
					cnt_q   <= '0;
					state_q <= B_LOG;
				end
				B_LOG: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 4'd15) state_q <= B_Y;
				end
				B_Y: begin
					cnt_q   <= '0;
					state_q <= B_EXP;
				end
				B_EXP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 4'd11) state_q <= B_SHG;
				end
				B_SHG: state_q <= B_MUL;
				B_MUL: state_q <= B_OUT;
				B_OUT: if (load_out) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule

### src/lrn_cross_channel_forward.sv
// Channel   | Dir | Handshake           | Payload
// in_ch     | in  | valid/ready         | sample[15:0] Q4.12, last_channel
// out_ch    | out | valid/ready         | normalized[15:0], scale_value[31:0], last_out
// apb       | in  | psel/penable/pready | paddr[3:0], pwdata/prdata[31:0]
//
// After an item is accepted, the front scales its square by alpha (F_MULQ), shifts it into
// the lines (F_SHIFT) and starts its window sums; each result is summed serially over its
// window and then pushed. The input is ready again only once the front is idle.
// The back takes one result at a time from the queue, when idle, and runs the log2 squaring
// loop and then the exp2 multiply loop, each on its own multiplier, before the final product.
// A 4-entry queue parts front and back, so a stalled output only stops the front
// once that queue is full. Reset clears the lines, the queue and all valid flags.
module lrn_cross_channel_forward import lrn_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	lrn_in_if.sink             in_ch,
	lrn_out_if.source          out_ch,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	logic [SZ_W-1:0]    window_size_q;
	logic [ALPHA_W-1:0] alpha_q;
	logic [BETA_W-1:0]  beta_q;
	reg_idx_t           ridx;

	logic       push, full, pop, empty;
	lrn_entry_t push_data, pop_data;

	assign pready = 1'b1;
	assign ridx   = reg_idx_t'(paddr[3:2]);

	// register writes complete in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= SZ_W'(5);
			alpha_q       <= ALPHA_W'(335);
			beta_q        <= BETA_W'(12288);
		end else if (psel && penable && pwrite) begin
			unique case (ridx)
				REG_WINDOW_SIZE: window_size_q <= pwdata[SZ_W-1:0];
				REG_ALPHA:       alpha_q       <= pwdata[ALPHA_W-1:0];
				REG_BETA:        beta_q        <= pwdata[BETA_W-1:0];
				REG_NONE:        ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_WINDOW_SIZE: prdata = 32'(window_size_q);
			REG_ALPHA:       prdata = 32'(alpha_q);
			REG_BETA:        prdata = 32'(beta_q);
			REG_NONE:        prdata = '0;
		endcase
	end

	// front: square, shift into the lines, sum each window, queue the result
	lrn_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_ch           (in_ch),
		.window_size     (window_size_q),
		.alpha_over_size (alpha_q),
		.push            (push),
		.push_data       (push_data),
		.full            (full)
	);

	lrn_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	// back: scale^-beta via log2/exp2 and the final product
	lrn_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.beta     (beta_q),
		.empty    (empty),
		.pop_data (pop_data),
		.pop      (pop),
		.out_ch   (out_ch)
	);
endmodule

### src/lrn_checker.sv
module lrn_checker import lrn_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [SCALE_W-1:0] out_scale,
	input logic [15:0]        out_norm,
	input logic               pready
);
	a_scale_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_scale >= ONE_Q22)
		else $error("scale below one");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_norm) && $stable(out_scale))
		else $error("stalled result changed");
endmodule

bind lrn_cross_channel_forward lrn_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_scale (out_ch.scale_value),
	.out_norm  (out_ch.normalized),
	.pready    (pready)
);

### tb/tb_lrn_cross_channel_forward.sv
`timescale 1ns / 100ps

module tb_lrn_cross_channel_forward;
	import lrn_pkg::*;

	typedef struct {
		logic [SAMPLE_W-1:0] sample;
		logic                last;
	} chan_item_t;

	typedef struct {
		logic [SAMPLE_W-1:0] normalized;
		logic [SCALE_W-1:0]  scale;
		logic                last;
	} norm_result_t;

	localparam int WATCHDOG_LIMIT = 6000;
	localparam int DRAIN_CYCLES   = 200;
	localparam int HOLD_CYCLES    = 400;

	// round(65536 * 2^(-2^-k)), k = 1..12
	localparam logic [15:0] ATTEN_STEP [12] = '{
		16'd46341, 16'd55109, 16'd60097, 16'd62757, 16'd64132, 16'd64830,
		16'd65182, 16'd65359, 16'd65447, 16'd65492, 16'd65514, 16'd65525
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	lrn_in_if  in_if ();
	lrn_out_if out_if ();

	lrn_cross_channel_forward i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_if.sink),
		.out_ch  (out_if.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow of the block's configuration and channel history
	logic [SZ_W-1:0]    win_size_reg = 4'd5;
	logic [ALPHA_W-1:0] alpha_reg    = 24'd335;
	logic [BETA_W-1:0]  beta_reg     = 16'd12288;
	logic [SQ_W-1:0]     square_hist [MAX_WINDOW];
	logic [SAMPLE_W-1:0] sample_hist [MAX_WINDOW];
	int                  chan_count;

	chan_item_t   pending_items [$];
	norm_result_t expected_norms [$];

	int send_idle_pct;
	int recv_idle_pct;
	int error_count;
	int stall_left;
	bit stall_armed;
	bit stall_done;
	int quiet_cycles;

	// Q4.16 log2 of a Q10.22 scale, fraction by repeated squaring
	function automatic logic [31:0] scale_log2(input logic [31:0] s);
		int msb;
		logic [63:0] m;
		logic [15:0] frac;
		msb = 31;
		frac = '0;
		if (s < ONE_Q22)
			return 32'd0;
		while (msb > 22 && !s[msb])
			msb--;
		if (msb >= 30)
			m = 64'(s) >> (msb - 30);
		else
			m = 64'(s) << (30 - msb);
		for (int i = 1; i <= 16; i++) begin
			m = (m * m) >> 30;
			if (m >= (64'd2 << 30)) begin
				m = m >> 1;
				frac[16 - i] = 1'b1;
			end
		end
		return {16'(msb - 22), frac};
	endfunction

	// Q1.16 gain 2^(-beta*log2(scale))
	function automatic logic [31:0] scale_gain(input logic [31:0] s);
		logic [63:0] y;
		logic [63:0] ipart;
		logic [11:0] fpart;
		logic [63:0] g;
		y = (64'(beta_reg) * 64'(scale_log2(s)) + (64'd1 << 17)) >> 18;
		ipart = y >> 12;
		fpart = y[11:0];
		g = 64'd65536;
		for (int k = 0; k < 12; k++)
			if (fpart[11 - k])
				g = (g * 64'(ATTEN_STEP[k]) + 64'd32768) >> 16;
		if (ipart >= 17)
			return 32'd0;
		return 32'(g >> ipart);
	endfunction

	function automatic norm_result_t channel_result(input int j, input int pre, input int post);
		norm_result_t r;
		int lo;
		int hi;
		logic [63:0] sum;
		logic [63:0] sc;
		longint p;
		longint v;
		lo = (j >= post) ? j - post : 0;
		hi = (j + pre > MAX_WINDOW - 1) ? MAX_WINDOW - 1 : j + pre;
		sum = '0;
		for (int i = lo; i <= hi; i++)
			sum += 64'(square_hist[i]);
		sc = 64'(ONE_Q22) + sum;
		if (sc > 64'hFFFF_FFFF)
			sc = 64'hFFFF_FFFF;
		p = longint'($signed(sample_hist[j])) * longint'(scale_gain(sc[31:0]));
		v = (p + 32768) >>> 16;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		r.normalized = v[15:0];
		r.scale = sc[31:0];
		r.last = 1'b0;
		return r;
	endfunction

	// Shift one channel in and queue the results it releases
	function automatic void predict_channel(input chan_item_t it);
		int sz;
		int pre;
		int post;
		int n;
		int flush_cnt;
		logic [63:0] ax;
		norm_result_t r;
		sz = int'(win_size_reg);
		if (sz < 1)
			sz = 1;
		if (sz > MAX_WINDOW)
			sz = MAX_WINDOW;
		pre = (sz - 1) / 2;
		post = sz - 1 - pre;
		n = 0;
		ax = ($signed(it.sample) < 0) ? 64'(-int'($signed(it.sample))) : 64'(it.sample);
		for (int i = MAX_WINDOW - 1; i > 0; i--) begin
			square_hist[i] = square_hist[i - 1];
			sample_hist[i] = sample_hist[i - 1];
		end
		square_hist[0] = 32'((ax * ax * 64'(alpha_reg) + (64'd1 << 25)) >> 26);
		sample_hist[0] = it.sample;
		if (chan_count >= post) begin
			expected_norms.push_back(channel_result(post, pre, post));
			n++;
		end
		if (chan_count < 15)
			chan_count++;
		if (it.last) begin
			flush_cnt = (chan_count < post) ? chan_count : post;
			for (int j = flush_cnt - 1; j >= 0; j--) begin
				expected_norms.push_back(channel_result(j, pre, post));
				n++;
			end
			// the vector's final result carries the end mark
			if (n > 0) begin
				r = expected_norms[$];
				r.last = 1'b1;
				expected_norms[$] = r;
			end
			for (int i = 0; i < MAX_WINDOW; i++) begin
				square_hist[i] = '0;
				sample_hist[i] = '0;
			end
			chan_count = 0;
		end
	endfunction

	// Driver: advance to the next pending item once the current one is taken
	always @(posedge clk) begin
		chan_item_t it;
		logic nxt_valid;
		logic [SAMPLE_W-1:0] nxt_sample;
		logic nxt_last;
		nxt_valid = in_if.valid;
		nxt_sample = in_if.sample;
		nxt_last = in_if.last_channel;
		if (arst_n) begin
			if (in_if.valid && in_if.ready) begin
				it.sample = in_if.sample;
				it.last = in_if.last_channel;
				predict_channel(it);
				nxt_valid = 1'b0;
			end
			if (!nxt_valid && pending_items.size() != 0 &&
					$urandom_range(99) >= send_idle_pct) begin
				it = pending_items.pop_front();
				nxt_valid = 1'b1;
				nxt_sample = it.sample;
				nxt_last = it.last;
			end
		end
		in_if.valid <= nxt_valid;
		in_if.sample <= nxt_sample;
		in_if.last_channel <= nxt_last;
	end

	// Monitor: compare each result with the oldest expectation, drive ready
	always @(posedge clk) begin
		norm_result_t exp_r;
		logic nxt_ready;
		if (arst_n) begin
			if (out_if.valid && out_if.ready) begin
				if (expected_norms.size() == 0) begin
					$error("unexpected result: normalized=%0h scale_value=%0h last_out=%0b",
						out_if.normalized, out_if.scale_value, out_if.last_out);
					error_count++;
				end else begin
					exp_r = expected_norms.pop_front();
					if (out_if.normalized !== exp_r.normalized) begin
						$error("normalized: expected %0h, got %0h",
							exp_r.normalized, out_if.normalized);
						error_count++;
					end
					if (out_if.scale_value !== exp_r.scale) begin
						$error("scale_value: expected %0h, got %0h",
							exp_r.scale, out_if.scale_value);
						error_count++;
					end
					if (out_if.last_out !== exp_r.last) begin
						$error("last_out: expected %0b, got %0b",
							exp_r.last, out_if.last_out);
						error_count++;
					end
				end
			end
			// long hold-off so the internal queue fills and the input backs up
			if (stall_armed && !stall_done) begin
				stall_left = HOLD_CYCLES;
				stall_done = 1'b1;
			end
			if (stall_left > 0) begin
				stall_left--;
				nxt_ready = 1'b0;
			end else begin
				nxt_ready = ($urandom_range(99) >= recv_idle_pct);
			end
			out_if.ready <= nxt_ready;
		end
	end

	// Watchdog: give up when nothing moves for too long
	always @(posedge clk) begin
		if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(4 * int'(idx));
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_WINDOW_SIZE: win_size_reg = value[SZ_W-1:0];
			REG_ALPHA:       alpha_reg = value[ALPHA_W-1:0];
			REG_BETA:        beta_reg = value[BETA_W-1:0];
			default: ;
		endcase
	endtask

	task automatic push_item(input logic [SAMPLE_W-1:0] s, input logic l);
		chan_item_t it;
		it.sample = s;
		it.last = l;
		pending_items.push_back(it);
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'($urandom_range(255));
			default: return 16'($urandom);
		endcase
	endfunction

	// Hold until every item is taken and every result seen, then let the front settle
	task automatic drain();
		while (pending_items.size() != 0 || in_if.valid || expected_norms.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic queue_vectors(input int n_items);
		int len;
		int left;
		left = n_items;
		while (left > 0) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 20);
			if (len > left)
				len = left;
			for (int i = 0; i < len; i++)
				push_item(pick_sample(), i == len - 1);
			left -= len;
		end
		// stray item: a partial vector that the next phase finishes
		if ($urandom_range(3) == 0)
			push_item(pick_sample(), 1'b0);
	endtask

	initial begin
		in_if.valid = 1'b0;
		in_if.sample = '0;
		in_if.last_channel = 1'b0;
		out_if.ready = 1'b0;
		error_count = 0;
		stall_left = 0;
		stall_armed = 1'b0;
		stall_done = 1'b0;
		quiet_cycles = 0;
		chan_count = 0;
		send_idle_pct = 32;
		recv_idle_pct = 55;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			square_hist[i] = '0;
			sample_hist[i] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings, field extremes, single-channel and short vectors
		push_item(16'h7FFF, 1'b0);
		push_item(16'h8000, 1'b0);
		push_item(16'h0000, 1'b0);
		push_item(16'h0001, 1'b0);
		push_item(16'hFFFF, 1'b1);
		push_item(16'h1000, 1'b1);
		push_item(16'h8000, 1'b0);
		push_item(16'h7FFF, 1'b1);
		for (int i = 0; i < 17; i++)
			push_item((i % 2) ? 16'h8000 : 16'h7FFF, 1'b0);
		drain();
		// change the window while a long vector is open
		write_reg(REG_WINDOW_SIZE, 32'd15);
		write_reg(REG_ALPHA, 32'hFF_FFFF);
		write_reg(REG_BETA, 32'hFFFF);
		push_item(16'h7FFF, 1'b0);
		push_item(16'h8000, 1'b1);
		push_item(16'h4000, 1'b1);
		drain();
		write_reg(REG_WINDOW_SIZE, 32'd0);
		write_reg(REG_BETA, 32'd0);
		push_item(16'h7FFF, 1'b0);
		push_item(16'h8000, 1'b1);
		drain();

		// Random phases over several settings and idle patterns
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_WINDOW_SIZE, 32'd5);
					write_reg(REG_ALPHA, 32'd335);
					write_reg(REG_BETA, 32'd12288);
				end
				1: begin
					write_reg(REG_WINDOW_SIZE, 32'd15);
					write_reg(REG_ALPHA, 32'hFF_FFFF);
					write_reg(REG_BETA, 32'hFFFF);
				end
				2: begin
					write_reg(REG_WINDOW_SIZE, 32'd1);
					write_reg(REG_ALPHA, 32'($urandom_range(24'hFF_FFFF)));
					write_reg(REG_BETA, 32'($urandom_range(16'hFFFF)));
				end
				3: begin
					write_reg(REG_WINDOW_SIZE, 32'd2);
					write_reg(REG_ALPHA, 32'd0);
					write_reg(REG_BETA, 32'd0);
				end
				default: begin
					write_reg(REG_WINDOW_SIZE, 32'($urandom_range(15)));
					write_reg(REG_ALPHA, 32'($urandom_range(24'hFF_FFFF)));
					write_reg(REG_BETA, 32'($urandom_range(16'hFFFF)));
				end
			endcase
			if (ph < 2) begin
				send_idle_pct = 32;
				recv_idle_pct = 55;
			end else if (ph < 4) begin
				send_idle_pct = 55;
				recv_idle_pct = 32;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			queue_vectors(80);
			if (ph == 4)
				stall_armed = 1'b1;
			drain();
		end
		// close any vector left open
		push_item(pick_sample(), 1'b1);
		drain();

		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
